[rtl/heater_load_shedding_controller_unit_defines.svh]
// ----------------------------------------------------------------------------
// Heater load-shedding controller: assertion macros
// Shared concurrent assertion forms for the checker of the controller.
// ----------------------------------------------------------------------------
`ifndef HEATER_LOAD_SHEDDING_CONTROLLER_UNIT_DEFINES_SVH
`define HEATER_LOAD_SHEDDING_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define HLSC_ASSERT_NOW(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("hlsc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge
`define HLSC_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("hlsc: next-cycle check failed");

`endif

[rtl/hlsc_pkg.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller package
// Types, register codes and fixed widths shared by the controller modules.
// ----------------------------------------------------------------------------
package hlsc_pkg;

   // Heater count and fixed field widths
   localparam int NUM_HEATERS    = 3;
   localparam int ELAPSED_BITS   = 8;
   localparam int MODE_BITS      = 2;
   localparam int INSTALLED_BITS = 2;
   localparam int THRESHOLD_BITS = 15;
   localparam int WAIT_BITS      = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COUNT_BITS     = 2;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHED_MODE  = 2'd0,
      CSR_INSTALLED  = 2'd1,
      CSR_THRESHOLD  = 2'd2,
      CSR_WAIT_TICKS = 2'd3
   } csr_index_type;

   // Shedding modes; every other code disables shedding
   localparam logic [MODE_BITS-1:0] MODE_CASCADE   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PER_PHASE = 2'd3;

   // Register reset values
   localparam logic [MODE_BITS-1:0]      RESET_SHED_MODE  = 2'd0;
   localparam logic [INSTALLED_BITS-1:0] RESET_INSTALLED  = 2'd3;
   localparam logic [THRESHOLD_BITS-1:0] RESET_THRESHOLD  = 15'd0;
   localparam logic [WAIT_BITS-1:0]      RESET_WAIT_TICKS = 16'd1000;

   // Output queue occupancy at which requests are refused
   localparam logic [COUNT_BITS-1:0] QUEUE_FULL = 2'd2;

   typedef struct packed {
      logic [MODE_BITS-1:0]      shed_mode;
      logic [INSTALLED_BITS-1:0] installed_heaters;
      logic [THRESHOLD_BITS-1:0] restore_threshold;
      logic [WAIT_BITS-1:0]      wait_ticks;
   } cfg_type;

   // What one phase lane reports to the merge stage
   typedef struct packed {
      logic timer_expired;
      logic head_negative;
      logic head_above;
   } lane_status_type;

   // One result; bit 0 is heater one
   typedef struct packed {
      logic [NUM_HEATERS-1:0] heater_on;
      logic [NUM_HEATERS-1:0] shed;
   } result_type;

endpackage

[rtl/hlsc_if.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller channels
// Valid/ready channels for phase samples in and heater drives out.
// ----------------------------------------------------------------------------
interface hlsc_req_if #(
   parameter int HEADROOM_BITS = 16
);
   logic                            valid;
   logic                            ready;
   logic signed [HEADROOM_BITS-1:0] headroom_1;
   logic signed [HEADROOM_BITS-1:0] headroom_2;
   logic signed [HEADROOM_BITS-1:0] headroom_3;
   logic                            fresh_1;
   logic                            fresh_2;
   logic                            fresh_3;
   logic                            demand_1;
   logic                            demand_2;
   logic                            demand_3;
   logic [7:0]                      elapsed;

   modport source (
      output valid, headroom_1, headroom_2, headroom_3,
             fresh_1, fresh_2, fresh_3, demand_1, demand_2, demand_3, elapsed,
      input  ready
   );
   modport sink (
      input  valid, headroom_1, headroom_2, headroom_3,
             fresh_1, fresh_2, fresh_3, demand_1, demand_2, demand_3, elapsed,
      output ready
   );
endinterface

interface hlsc_rsp_if;
   logic valid;
   logic ready;
   logic heater_on_1;
   logic heater_on_2;
   logic heater_on_3;
   logic shed_1;
   logic shed_2;
   logic shed_3;

   modport source (
      output valid, heater_on_1, heater_on_2, heater_on_3, shed_1, shed_2, shed_3,
      input  ready
   );
   modport sink (
      input  valid, heater_on_1, heater_on_2, heater_on_3, shed_1, shed_2, shed_3,
      output ready
   );
endinterface

[rtl/hlsc_lane.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller phase lane
// Restore timer of one heater and the headroom compares of its phase.
// ----------------------------------------------------------------------------
module hlsc_lane #(
   parameter int HEADROOM_BITS = 16,
   parameter int TIMER_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [hlsc_pkg::ELAPSED_BITS-1:0]    elapsed,
   input  logic signed [HEADROOM_BITS-1:0]      headroom,
   input  logic [hlsc_pkg::THRESHOLD_BITS-1:0]  restore_threshold,
   input  logic [hlsc_pkg::WAIT_BITS-1:0]       wait_ticks,
   input  logic                                 clear_timer,
   output hlsc_pkg::lane_status_type            status
);
   import hlsc_pkg::*;

   localparam int SUM_BITS = TIMER_BITS + 1;
   localparam int CMP_BITS = (TIMER_BITS > WAIT_BITS) ? TIMER_BITS : WAIT_BITS;
   localparam int HEAD_EXT_BITS =
      ((HEADROOM_BITS > THRESHOLD_BITS) ? HEADROOM_BITS : THRESHOLD_BITS) + 1;

   logic [TIMER_BITS-1:0]           timer_ff;
   logic [TIMER_BITS-1:0]           timer_in;
   logic [SUM_BITS-1:0]             timer_sum;
   logic [TIMER_BITS-1:0]           timer_sat;
   logic signed [HEAD_EXT_BITS-1:0] head_ext;
   logic signed [HEAD_EXT_BITS-1:0] thr_ext;

   // Advance the timer by the elapsed ticks, holding at full scale
   assign timer_sum = {1'b0, timer_ff} + SUM_BITS'(elapsed);
   assign timer_sat = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : timer_sum[TIMER_BITS-1:0];

   // Compare headroom against zero and the restore threshold
   assign head_ext = {{(HEAD_EXT_BITS - HEADROOM_BITS){headroom[HEADROOM_BITS-1]}}, headroom};
   assign thr_ext  = {{(HEAD_EXT_BITS - THRESHOLD_BITS){1'b0}}, restore_threshold};

   assign status.timer_expired = CMP_BITS'(timer_sat) > CMP_BITS'(wait_ticks);
   assign status.head_negative = headroom[HEADROOM_BITS-1];
   assign status.head_above    = head_ext > thr_ext;

   // Drop the timer to zero when the merge stage takes a restore decision
   assign timer_in = clear_timer ? '0 : timer_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
      end else if (advance) begin
         timer_ff <= timer_in;
      end
   end

endmodule

[rtl/hlsc_merge.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller merge stage
// Combines the lane reports into shed flags, timer clears and heater drives.
// ----------------------------------------------------------------------------
module hlsc_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [hlsc_pkg::MODE_BITS-1:0]       shed_mode,
   input  logic [hlsc_pkg::INSTALLED_BITS-1:0]  installed_heaters,
   input  logic [hlsc_pkg::NUM_HEATERS-1:0]     fresh,
   input  logic [hlsc_pkg::NUM_HEATERS-1:0]     demand,
   input  hlsc_pkg::lane_status_type            status [hlsc_pkg::NUM_HEATERS],
   output logic [hlsc_pkg::NUM_HEATERS-1:0]     clear_timer,
   output hlsc_pkg::result_type                 result
);
   import hlsc_pkg::*;

   logic [NUM_HEATERS-1:0] shed_flags_ff;
   logic [NUM_HEATERS-1:0] shed_flags_in;
   logic [NUM_HEATERS-1:0] fitted;

   // Decide new shed flags and which timers restart
   always_comb begin
      shed_flags_in = shed_flags_ff;
      clear_timer   = '0;
      case (shed_mode)
         MODE_CASCADE: begin
            if (fresh[0]) begin
               if (status[0].head_negative) begin
                  // shed the lowest-priority heater still running
                  if (!shed_flags_ff[2]) begin
                     shed_flags_in[2] = 1'b1;
                  end else if (!shed_flags_ff[1]) begin
                     shed_flags_in[1] = 1'b1;
                  end else if (!shed_flags_ff[0]) begin
                     shed_flags_in[0] = 1'b1;
                  end
               end else begin
                  // restore at most one heater, highest priority first
                  if (shed_flags_ff[0] && status[0].timer_expired) begin
                     clear_timer[0] = 1'b1;
                     if (status[0].head_above) begin
                        shed_flags_in[0] = 1'b0;
                     end
                  end else if (shed_flags_ff[1] && status[1].timer_expired) begin
                     clear_timer[1] = 1'b1;
                     if (status[0].head_above) begin
                        shed_flags_in[1] = 1'b0;
                     end
                  end else if (shed_flags_ff[2] && status[2].timer_expired) begin
                     clear_timer[2] = 1'b1;
                     if (status[0].head_above) begin
                        shed_flags_in[2] = 1'b0;
                     end
                  end
               end
            end
         end
         MODE_PER_PHASE: begin
            for (int k = 0; k < NUM_HEATERS; k++) begin
               if (status[k].head_negative) begin
                  if (fresh[k]) begin
                     shed_flags_in[k] = 1'b1;
                  end
               end else if (status[k].timer_expired) begin
                  clear_timer[k] = 1'b1;
                  if (status[k].head_above) begin
                     shed_flags_in[k] = 1'b0;
                  end
               end
            end
         end
         default: begin
            shed_flags_in = '0;
         end
      endcase
   end

   // Gate each demand by its shed flag and the installed count
   always_comb begin
      for (int k = 0; k < NUM_HEATERS; k++) begin
         fitted[k] = installed_heaters > INSTALLED_BITS'(k);
      end
   end

   assign result.shed      = shed_flags_in;
   assign result.heater_on = demand & ~shed_flags_in & fitted;

   always_ff @(posedge clock) begin
      if (reset) begin
         shed_flags_ff <= '0;
      end else if (advance) begin
         shed_flags_ff <= shed_flags_in;
      end
   end

endmodule

[rtl/heater_load_shedding_controller_unit.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller
// Three-heater priority shedding with restore timers and demand gating.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle, back to back. A request goes through
// the three phase lanes (timer advance and headroom compares) and the merge
// stage in the cycle it is accepted, and its result is registered into a
// two-entry output queue and offered from its head. The request side stalls
// only while both queue entries hold results not yet taken. Register writes
// take effect on the cycle after the write and are meant for idle time.
module heater_load_shedding_controller_unit #(
   parameter int HEADROOM_BITS = 16,
   parameter int TIMER_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [hlsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hlsc_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   hlsc_req_if.sink                             req_channel,
   hlsc_rsp_if.source                           rsp_channel
);
   import hlsc_pkg::*;

   cfg_type                         cfg_ff;
   logic                            advance;
   logic                            pop;
   logic signed [HEADROOM_BITS-1:0] headroom [NUM_HEATERS];
   logic [NUM_HEATERS-1:0]          fresh;
   logic [NUM_HEATERS-1:0]          demand;
   lane_status_type                 status [NUM_HEATERS];
   logic [NUM_HEATERS-1:0]          clear_timer;
   result_type                      result;
   result_type                      slot0_ff;
   result_type                      slot0_in;
   result_type                      slot1_ff;
   result_type                      slot1_in;
   logic [COUNT_BITS-1:0]           count_ff;
   logic [COUNT_BITS-1:0]           count_in;
   logic [COUNT_BITS-1:0]           count_left;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shed_mode         <= RESET_SHED_MODE;
         cfg_ff.installed_heaters <= RESET_INSTALLED;
         cfg_ff.restore_threshold <= RESET_THRESHOLD;
         cfg_ff.wait_ticks        <= RESET_WAIT_TICKS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SHED_MODE:  cfg_ff.shed_mode         <= csr_write_data[MODE_BITS-1:0];
            CSR_INSTALLED:  cfg_ff.installed_heaters <= csr_write_data[INSTALLED_BITS-1:0];
            CSR_THRESHOLD:  cfg_ff.restore_threshold <= csr_write_data[THRESHOLD_BITS-1:0];
            CSR_WAIT_TICKS: cfg_ff.wait_ticks        <= csr_write_data[WAIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request handshake
   assign req_channel.ready = count_ff != QUEUE_FULL;
   assign advance           = req_channel.valid && req_channel.ready;

   assign headroom[0] = req_channel.headroom_1;
   assign headroom[1] = req_channel.headroom_2;
   assign headroom[2] = req_channel.headroom_3;
   assign fresh  = {req_channel.fresh_3, req_channel.fresh_2, req_channel.fresh_1};
   assign demand = {req_channel.demand_3, req_channel.demand_2, req_channel.demand_1};

   // One lane per phase
   for (genvar k = 0; k < NUM_HEATERS; k++) begin : g_lane
      hlsc_lane #(
         .HEADROOM_BITS (HEADROOM_BITS),
         .TIMER_BITS    (TIMER_BITS)
      ) u_lane (
         .clock             (clock),
         .reset             (reset),
         .advance           (advance),
         .elapsed           (req_channel.elapsed),
         .headroom          (headroom[k]),
         .restore_threshold (cfg_ff.restore_threshold),
         .wait_ticks        (cfg_ff.wait_ticks),
         .clear_timer       (clear_timer[k]),
         .status            (status[k])
      );
   end

   hlsc_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .shed_mode         (cfg_ff.shed_mode),
      .installed_heaters (cfg_ff.installed_heaters),
      .fresh             (fresh),
      .demand            (demand),
      .status            (status),
      .clear_timer       (clear_timer),
      .result            (result)
   );

   // Output queue: pop shifts the second entry forward, push fills the next free one
   assign pop        = rsp_channel.valid && rsp_channel.ready;
   assign count_left = count_ff - COUNT_BITS'(pop);

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (advance) begin
         if (count_left == '0) begin
            slot0_in = result;
         end else begin
            slot1_in = result;
         end
      end
      count_in = count_left + COUNT_BITS'(advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Present the head of the queue
   assign rsp_channel.valid       = count_ff != '0;
   assign rsp_channel.heater_on_1 = slot0_ff.heater_on[0];
   assign rsp_channel.heater_on_2 = slot0_ff.heater_on[1];
   assign rsp_channel.heater_on_3 = slot0_ff.heater_on[2];
   assign rsp_channel.shed_1      = slot0_ff.shed[0];
   assign rsp_channel.shed_2      = slot0_ff.shed[1];
   assign rsp_channel.shed_3      = slot0_ff.shed[2];

endmodule

[rtl/hlsc_checker.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller checker
// Port-level checks of the controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "heater_load_shedding_controller_unit_defines.svh"

module hlsc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic heater_on_1,
   input logic heater_on_2,
   input logic heater_on_3,
   input logic shed_1,
   input logic shed_2,
   input logic shed_3
);

   // An accepted request always leaves a result on the next cycle
   `HLSC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // A shed heater is never driven
   `HLSC_ASSERT_NOW(a_shed_not_on, clock, reset, rsp_valid, !(heater_on_1 && shed_1) && !(heater_on_2 && shed_2) && !(heater_on_3 && shed_3))

   // Reset empties the output queue
   `HLSC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // A waiting result stays offered
   `HLSC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind heater_load_shedding_controller_unit hlsc_checker u_hlsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_channel.valid),
   .req_ready   (req_channel.ready),
   .rsp_valid   (rsp_channel.valid),
   .rsp_ready   (rsp_channel.ready),
   .heater_on_1 (rsp_channel.heater_on_1),
   .heater_on_2 (rsp_channel.heater_on_2),
   .heater_on_3 (rsp_channel.heater_on_3),
   .shed_1      (rsp_channel.shed_1),
   .shed_2      (rsp_channel.shed_2),
   .shed_3      (rsp_channel.shed_3)
);

[test/tb_heater_load_shedding_controller_unit.sv]
// ----------------------------------------------------------------------------
// Heater load-shedding controller testbench
// Drives phase samples through the request channel under random gaps and
// stalls, keeps its own copy of the shed flags and restore timers, and checks
// each heater drive result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_heater_load_shedding_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import hlsc_pkg::*;

   // One phase sample as carried by a request; bit 0 of each triple is phase one
   typedef struct packed {
      logic [15:0] headroom_1;
      logic [15:0] headroom_2;
      logic [15:0] headroom_3;
      logic [2:0]  fresh;
      logic [2:0]  demand;
      logic [7:0]  elapsed;
   } phase_sample_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   hlsc_req_if #(.HEADROOM_BITS(16)) req_bus ();
   hlsc_rsp_if                       rsp_bus ();

   heater_load_shedding_controller_unit #(
      .HEADROOM_BITS(16),
      .TIMER_BITS(16)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus)
   );

   // Shadow registers and state of the controller
   logic [MODE_BITS-1:0]      cfg_mode;
   logic [INSTALLED_BITS-1:0] cfg_installed;
   logic [THRESHOLD_BITS-1:0] cfg_threshold;
   logic [WAIT_BITS-1:0]      cfg_wait;
   logic [2:0]                model_shed;
   logic [15:0]               model_timer [3];

   result_type pending_drives [$];
   int         error_count     = 0;
   bit         sender_gaps     = 1'b1;
   bit         receiver_stalls = 1'b1;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: take results, stalling now and then
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = (receiver_stalls && $urandom_range(99) < 15) ? 1'b0 : 1'b1;
      end
   end

   function automatic bit headroom_above(input logic [15:0] head);
      return $signed(head) > $signed({1'b0, cfg_threshold});
   endfunction

   // Advance the timers, apply the shedding mode and form the heater drives
   function automatic result_type advance_heaters(input phase_sample_type s);
      logic [15:0] head [3];
      logic [16:0] sum;
      logic        handled;
      result_type  drive;
      head[0] = s.headroom_1;
      head[1] = s.headroom_2;
      head[2] = s.headroom_3;
      for (int k = 0; k < 3; k++) begin
         sum = {1'b0, model_timer[k]} + {9'd0, s.elapsed};
         model_timer[k] = sum[16] ? 16'hFFFF : sum[15:0];
      end
      if (cfg_mode == MODE_CASCADE) begin
         if (s.fresh[0]) begin
            if (head[0][15]) begin
               // shed the lowest priority heater still running
               if (!model_shed[2]) model_shed[2] = 1'b1;
               else if (!model_shed[1]) model_shed[1] = 1'b1;
               else if (!model_shed[0]) model_shed[0] = 1'b1;
            end else begin
               // handle at most one heater, highest priority first
               handled = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  if (!handled && model_shed[k] && model_timer[k] > cfg_wait) begin
                     if (headroom_above(head[0])) model_shed[k] = 1'b0;
                     model_timer[k] = '0;
                     handled = 1'b1;
                  end
               end
            end
         end
      end else if (cfg_mode == MODE_PER_PHASE) begin
         for (int k = 0; k < 3; k++) begin
            if (head[k][15]) begin
               if (s.fresh[k]) model_shed[k] = 1'b1;
            end else if (model_timer[k] > cfg_wait) begin
               if (headroom_above(head[k])) model_shed[k] = 1'b0;
               model_timer[k] = '0;
            end
         end
      end else begin
         model_shed = '0;
      end
      for (int k = 0; k < 3; k++)
         drive.heater_on[k] = s.demand[k] && (k + 1 <= cfg_installed) && !model_shed[k];
      drive.shed = model_shed;
      return drive;
   endfunction

   function automatic phase_sample_type observed_sample();
      phase_sample_type s;
      s.headroom_1 = req_bus.headroom_1;
      s.headroom_2 = req_bus.headroom_2;
      s.headroom_3 = req_bus.headroom_3;
      s.fresh      = {req_bus.fresh_3, req_bus.fresh_2, req_bus.fresh_1};
      s.demand     = {req_bus.demand_3, req_bus.demand_2, req_bus.demand_1};
      s.elapsed    = req_bus.elapsed;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   // Compare one result against the oldest expected drive
   task automatic check_drive();
      result_type want;
      result_type got;
      got.heater_on = {rsp_bus.heater_on_3, rsp_bus.heater_on_2, rsp_bus.heater_on_1};
      got.shed      = {rsp_bus.shed_3, rsp_bus.shed_2, rsp_bus.shed_1};
      if (pending_drives.size() == 0) begin
         report_mismatch($sformatf("result %b with none expected", got));
      end else begin
         want = pending_drives.pop_front();
         for (int k = 0; k < 3; k++) begin
            if (got.heater_on[k] !== want.heater_on[k])
               report_mismatch($sformatf("heater_on_%0d got %b want %b",
                                         k + 1, got.heater_on[k], want.heater_on[k]));
            if (got.shed[k] !== want.shed[k])
               report_mismatch($sformatf("shed_%0d got %b want %b",
                                         k + 1, got.shed[k], want.shed[k]));
         end
      end
   endtask

   // Predict on each accepted request, check on each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            pending_drives.push_back(advance_heaters(observed_sample()));
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_drive();
      end
   end

   // Send one request and hold it until it is accepted
   task automatic send_request(input phase_sample_type s);
      while (sender_gaps && $urandom_range(99) < 15) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.headroom_1 = s.headroom_1;
      req_bus.headroom_2 = s.headroom_2;
      req_bus.headroom_3 = s.headroom_3;
      {req_bus.fresh_3, req_bus.fresh_2, req_bus.fresh_1}    = s.fresh;
      {req_bus.demand_3, req_bus.demand_2, req_bus.demand_1} = s.demand;
      req_bus.elapsed = s.elapsed;
      req_bus.valid   = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Drop valid and wait for every expected result
   task automatic wait_until_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      case (idx)
         CSR_SHED_MODE:  cfg_mode      = data[MODE_BITS-1:0];
         CSR_INSTALLED:  cfg_installed = data[INSTALLED_BITS-1:0];
         CSR_THRESHOLD:  cfg_threshold = data[THRESHOLD_BITS-1:0];
         CSR_WAIT_TICKS: cfg_wait      = data[WAIT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Write all four registers, with junk in the unused upper bits
   task automatic configure_block(input logic [1:0] mode, input logic [1:0] fitted,
                                  input logic [14:0] thr, input logic [15:0] wait_limit);
      logic [15:0] junk;
      wait_until_idle();
      junk = 16'($urandom);
      write_register(CSR_SHED_MODE, {junk[15:2], mode});
      write_register(CSR_INSTALLED, {junk[13:0], fitted});
      write_register(CSR_THRESHOLD, {junk[0], thr});
      write_register(CSR_WAIT_TICKS, wait_limit);
   endtask

   function automatic phase_sample_type make_sample(input int h1, input int h2, input int h3,
                                                    input logic [2:0] fresh,
                                                    input logic [2:0] demand,
                                                    input int elapsed);
      phase_sample_type s;
      s.headroom_1 = 16'(h1);
      s.headroom_2 = 16'(h2);
      s.headroom_3 = 16'(h3);
      s.fresh      = fresh;
      s.demand     = demand;
      s.elapsed    = 8'(elapsed);
      return s;
   endfunction

   // Overloads, values around the threshold, extremes and plain noise
   function automatic int random_headroom();
      int v;
      case ($urandom_range(9))
         0, 1, 2: begin
            v = -int'($urandom_range(32768, 1));
         end
         3, 4: begin
            v = int'(cfg_threshold) + int'($urandom_range(4)) - 2;
            if (v > 32767) v = 32767;
         end
         5: begin
            case ($urandom_range(3))
               0: v = 0;
               1: v = -1;
               2: v = 32767;
               default: v = -32768;
            endcase
         end
         default: begin
            v = int'($urandom_range(65535)) - 32768;
         end
      endcase
      return v;
   endfunction

   function automatic phase_sample_type random_sample(input int elapsed_fixed);
      int ticks;
      case ($urandom_range(9))
         0, 1:    ticks = 0;
         2:       ticks = 255;
         default: ticks = $urandom_range(255);
      endcase
      if (elapsed_fixed >= 0) ticks = elapsed_fixed;
      return make_sample(random_headroom(), random_headroom(), random_headroom(),
                         {$urandom_range(3) != 0, $urandom_range(3) != 0,
                          $urandom_range(3) != 0},
                         3'($urandom), ticks);
   endfunction

   function automatic logic [14:0] pick_threshold();
      case ($urandom_range(3))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'($urandom_range(200));
         default: return 15'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_wait();
      case ($urandom_range(4))
         0:       return 16'd0;
         1:       return 16'd1000;
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(800));
      endcase
   endfunction

   // One phase of random requests; a drain pause falls half way when asked
   task automatic run_random_phase(input int count, input int elapsed_fixed,
                                   input bit drain_pause);
      for (int n = 0; n < count; n++) begin
         if (drain_pause && n == count / 2) wait_until_idle();
         send_request(random_sample(elapsed_fixed));
      end
   endtask

   // Reset register values: shedding off, overloads ignored
   task automatic test_disabled_modes();
      send_request(make_sample(-1, -32768, -5, 3'b111, 3'b111, 255));
      send_request(make_sample(32767, 0, -1, 3'b101, 3'b010, 0));
      configure_block(2'd2, 2'd3, 15'd0, 16'd0);
      send_request(make_sample(-1, -1, -1, 3'b111, 3'b111, 7));
   endtask

   // Shed 3, 2, 1 on phase one overloads, restore 1 and 2
   task automatic test_cascade_order();
      configure_block(MODE_CASCADE, 2'd3, 15'd100, 16'd10);
      send_request(make_sample(-1, 5, 5, 3'b001, 3'b111, 0));
      send_request(make_sample(-32768, 5, 5, 3'b001, 3'b111, 0));
      send_request(make_sample(-3, 5, 5, 3'b110, 3'b111, 0));
      send_request(make_sample(-3, -3, -3, 3'b111, 3'b111, 0));
      send_request(make_sample(-3, 5, 5, 3'b001, 3'b111, 0));
      // headroom not above threshold: timer cleared, flag kept
      send_request(make_sample(50, 5, 5, 3'b001, 3'b111, 20));
      send_request(make_sample(100, 5, 5, 3'b001, 3'b111, 5));
      send_request(make_sample(32767, 5, 5, 3'b001, 3'b111, 11));
      send_request(make_sample(101, 5, 5, 3'b001, 3'b111, 0));
      send_request(make_sample(101, 5, 5, 3'b000, 3'b111, 0));
      send_request(make_sample(0, 5, 5, 3'b001, 3'b111, 0));
   endtask

   // Each phase sheds and restores its own heater
   task automatic test_per_phase_lanes();
      configure_block(MODE_PER_PHASE, 2'd3, 15'd0, 16'd0);
      send_request(make_sample(-1, -1, -1, 3'b111, 3'b111, 0));
      send_request(make_sample(-5, 0, 5, 3'b000, 3'b111, 1));
      send_request(make_sample(1, 32767, -32768, 3'b100, 3'b111, 1));
      send_request(make_sample(1, 1, 1, 3'b000, 3'b000, 1));
   endtask

   // Heaters beyond the installed count stay off, but still shed
   task automatic test_installed_count();
      configure_block(MODE_PER_PHASE, 2'd0, 15'd0, 16'd1000);
      send_request(make_sample(1, 1, 1, 3'b000, 3'b111, 0));
      configure_block(MODE_PER_PHASE, 2'd1, 15'd0, 16'd1000);
      send_request(make_sample(1, 1, -1, 3'b100, 3'b111, 0));
      configure_block(MODE_PER_PHASE, 2'd2, 15'd0, 16'd1000);
      send_request(make_sample(1, -1, 1, 3'b010, 3'b111, 0));
   endtask

   // Run the timers into saturation, then restore at the top of the range
   task automatic test_timer_saturation();
      configure_block(2'd0, 2'd3, pick_threshold(), 16'hFFFF);
      run_random_phase(265, 255, 1'b0);
      configure_block(MODE_PER_PHASE, 2'd3, pick_threshold(), 16'hFFFE);
      run_random_phase(30, 255, 1'b0);
      configure_block(MODE_CASCADE, 2'd3, pick_threshold(), 16'hFFFF);
      run_random_phase(30, 255, 1'b0);
   endtask

   task automatic test_random_settings();
      logic [1:0] modes [6];
      modes = '{MODE_CASCADE, MODE_PER_PHASE, 2'd0, MODE_CASCADE, MODE_PER_PHASE, 2'd2};
      for (int p = 0; p < 6; p++) begin
         configure_block(modes[p], 2'($urandom_range(3)), pick_threshold(), pick_wait());
         run_random_phase(90, -1, 1'b0);
      end
   endtask

   // Long stretch with requests and results back to back
   task automatic test_back_to_back();
      configure_block(MODE_CASCADE, 2'd3, 15'($urandom_range(100)), 16'($urandom_range(300)));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      run_random_phase(150, -1, 1'b0);
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Hold the sender until every result is in, then carry on
   task automatic test_drain_pause();
      configure_block(MODE_PER_PHASE, 2'd3, pick_threshold(), 16'($urandom_range(400)));
      run_random_phase(150, -1, 1'b1);
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_SHED_MODE;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.headroom_1 = '0;
      req_bus.headroom_2 = '0;
      req_bus.headroom_3 = '0;
      req_bus.fresh_1    = 1'b0;
      req_bus.fresh_2    = 1'b0;
      req_bus.fresh_3    = 1'b0;
      req_bus.demand_1   = 1'b0;
      req_bus.demand_2   = 1'b0;
      req_bus.demand_3   = 1'b0;
      req_bus.elapsed    = '0;
      cfg_mode           = RESET_SHED_MODE;
      cfg_installed      = RESET_INSTALLED;
      cfg_threshold      = RESET_THRESHOLD;
      cfg_wait           = RESET_WAIT_TICKS;
      model_shed         = '0;
      for (int k = 0; k < 3; k++) model_timer[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_modes();
      test_cascade_order();
      test_per_phase_lanes();
      test_installed_count();
      test_timer_saturation();
      test_random_settings();
      test_back_to_back();
      test_drain_pause();

      // drain, then wait for stray results
      wait_until_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
